/* rtl/core/lcg48_pkg.sv */
// lcg48_pkg: request codes, register indexes and fixed widths of the
// 48-bit congruential generator; used by every module under rtl/core
`default_nettype none

package lcg48_pkg;

	// width of the configuration registers and of their write data
	localparam int CFG_W = 48;
	// multiplier digit taken per step-unit cycle
	localparam int MUL_DIGIT_W = 16;
	// widest single draw
	localparam int DRAW_W = 32;
	// magnitude bits of a positive bound, also the divider width
	localparam int BOUND_W = 31;
	// counter of rejected bounded draws
	localparam int TRIES_W = 10;
	localparam logic [TRIES_W-1:0] TRIES_LAST = '1;
	// significand window of the fraction normalizer (double precision)
	localparam int FRAC_W = 53;
	localparam int FLOAT_PAD = 29;
	localparam int SHIFT_W = 6;
	// exponent of a normalized value with no shifts applied
	localparam logic [7:0]  FLOAT_EXP_BASE  = 8'd126;
	localparam logic [10:0] DOUBLE_EXP_BASE = 11'd1022;
	// draw widths of the individual requests
	localparam logic [5:0] BITS_INT    = 6'd32;
	localparam logic [5:0] BITS_BOUND  = 6'd31;
	localparam logic [5:0] BITS_BOOL   = 6'd1;
	localparam logic [5:0] BITS_FLOAT  = 6'd24;
	localparam logic [5:0] BITS_DBL_HI = 6'd26;
	localparam logic [5:0] BITS_DBL_LO = 6'd27;

	typedef enum logic [2:0] {
		REQ_SET_SEED = 3'd0,
		REQ_INT      = 3'd1,
		REQ_BOUNDED  = 3'd2,
		REQ_LONG     = 3'd3,
		REQ_BOOL     = 3'd4,
		REQ_FLOAT    = 3'd5,
		REQ_DOUBLE   = 3'd6,
		REQ_RAW      = 3'd7
	} req_type_t;

	typedef enum logic [0:0] {
		CFG_MULTIPLIER = 1'b0,
		CFG_INCREMENT  = 1'b1
	} cfg_reg_t;

endpackage

`default_nettype wire

/* rtl/core/lcg48_random_generator.sv */
// lcg48_random_generator: typed requests, one word at a time; a draw runs the step unit
// (3 digit multiplies) and then a use state; int, boolean and raw take one draw, long two,
// set seed and bad bound none; a new word is taken only after the last one leaves S_DONE
// float/double then normalize unless zero; non-power-of-two bounds use the divider per try
// a finished word waits in an output register while the next word is taken
// arst_n clears the seed to zero and loads the default multiplier and increment
`default_nettype none

module lcg48_random_generator import lcg48_pkg::*; #(
	parameter int SEED_WIDTH = 48
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// slave side
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	// seed_value[63:0], upper_bound[95:64], bit_count[101:96], zero pad
	input  wire logic [103:0]      s_tdata,
	// req_type[2:0]
	input  wire logic [2:0]        s_tuser,
	// master side
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	// result_value[63:0], status[64], zero pad
	output logic [71:0]            m_tdata,
	// configuration
	input  wire logic              cfg_we,
	input  wire logic [0:0]        cfg_index,
	input  wire logic [CFG_W-1:0]  cfg_data
);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_STEP = 6'b000010,
		S_USE  = 6'b000100,
		S_DIV  = 6'b001000,
		S_NORM = 6'b010000,
		S_DONE = 6'b100000
	} state_t;

	state_t                 state_q;
	logic                   out_valid_q;
	logic                   step_start_q;
	logic                   div_start_q;
	logic [SEED_WIDTH-1:0]  seed_q;
	logic [CFG_W-1:0]       mult_q;
	logic [CFG_W-1:0]       inc_q;
	logic [TRIES_W-1:0]     tries_q;
	logic                   second_q;

	req_type_t              req_q;
	logic [5:0]             nbits_q;
	logic [BOUND_W-1:0]     bound_q;
	logic                   pow2_q;
	logic [DRAW_W-1:0]      hi_q;
	logic [BOUND_W-1:0]     draw31_q;
	logic [FRAC_W-1:0]      norm_q;
	logic [SHIFT_W-1:0]     sh_q;
	logic [63:0]            res_q;
	logic                   stat_q;
	logic [63:0]            out_result_q;
	logic                   out_status_q;

	logic                   accept;
	logic                   out_load;
	req_type_t              in_req;
	logic [31:0]            in_bound;
	logic [5:0]             in_bits;
	logic                   in_bad_bound;
	logic                   step_done;
	logic [SEED_WIDTH-1:0]  step_next;
	logic                   div_done;
	logic [BOUND_W-1:0]     div_rem;
	logic [5:0]             draw_n;
	logic [DRAW_W-1:0]      d;
	logic [2*BOUND_W-1:0]   pow_prod;
	logic [FRAC_W-1:0]      frac_v;
	logic [63:0]            use_res;
	logic                   use_more;
	logic                   use_div;
	logic                   use_norm;
	logic [32:0]            rej_sum;
	logic                   reject;
	logic                   retry;
	logic [7:0]             exp_f;
	logic [10:0]            exp_d;
	logic [63:0]            norm_res;

	// top n bits of a seed, zero for n of zero
	function automatic logic [DRAW_W-1:0] take_bits(input logic [SEED_WIDTH-1:0] s,
			input logic [5:0] n);
		logic [63:0] s64;
		logic [6:0]  sh;
		s64 = 64'(s);
		sh  = 7'(SEED_WIDTH) - 7'(n);
		if (n == 6'd0)
			take_bits = '0;
		else
			take_bits = 32'(s64 >> sh);
	endfunction

	// input word fields
	assign accept       = s_tvalid && s_tready;
	assign in_req       = req_type_t'(s_tuser);
	assign in_bound     = s_tdata[95:64];
	assign in_bits      = (s_tdata[101:96] > BITS_INT) ? BITS_INT : s_tdata[101:96];
	assign in_bad_bound = (in_bound == 32'd0) || in_bound[31];
	assign out_load     = (state_q == S_DONE) && (!out_valid_q || m_tready);

	// shared step unit
	lcg48_step #(
		.SEED_WIDTH(SEED_WIDTH)
	) u_step (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (step_start_q),
		.seed     (seed_q),
		.mult     (mult_q),
		.inc      (inc_q),
		.done     (step_done),
		.next_seed(step_next)
	);

	// remainder unit for bounded draws
	lcg48_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (draw31_q),
		.divisor  (bound_q),
		.done     (div_done),
		.remainder(div_rem)
	);

	// draw width of the current request
	always_comb begin
		case (req_q)
			REQ_INT, REQ_LONG: draw_n = BITS_INT;
			REQ_BOUNDED:       draw_n = BITS_BOUND;
			REQ_BOOL:          draw_n = BITS_BOOL;
			REQ_FLOAT:         draw_n = BITS_FLOAT;
			REQ_DOUBLE:        draw_n = second_q ? BITS_DBL_LO : BITS_DBL_HI;
			REQ_RAW:           draw_n = nbits_q;
			default:           draw_n = '0;
		endcase
	end

	assign d        = take_bits(seed_q, draw_n);
	assign pow_prod = bound_q * d[BOUND_W-1:0];

	// result of a finished draw and what comes next
	always_comb begin
		use_res  = '0;
		use_more = 1'b0;
		use_div  = 1'b0;
		use_norm = 1'b0;
		frac_v   = '0;
		case (req_q)
			REQ_INT:     use_res = {{32{d[31]}}, d};
			REQ_BOUNDED: begin
				if (pow2_q)
					use_res = 64'(pow_prod[2*BOUND_W-1:BOUND_W]);
				else
					use_div = 1'b1;
			end
			REQ_LONG: begin
				if (!second_q)
					use_more = 1'b1;
				else
					use_res = {hi_q, 32'b0} + {{32{d[31]}}, d};
			end
			REQ_BOOL:    use_res = 64'(d[0]);
			REQ_FLOAT: begin
				frac_v   = {d[23:0], {FLOAT_PAD{1'b0}}};
				use_norm = (frac_v != '0);
			end
			REQ_DOUBLE: begin
				if (!second_q) begin
					use_more = 1'b1;
				end else begin
					frac_v   = {hi_q[25:0], d[26:0]};
					use_norm = (frac_v != '0);
				end
			end
			REQ_RAW:     use_res = 64'(d);
			default:     use_res = '0;
		endcase
	end

	// bias check of a bounded draw
	assign rej_sum = 33'(draw31_q) - 33'(div_rem) + 33'(bound_q) - 33'd1;
	assign reject  = rej_sum > 33'h0_7FFF_FFFF;
	assign retry   = reject && (tries_q != TRIES_LAST);

	// packing of a normalized fraction
	assign exp_f = FLOAT_EXP_BASE - 8'(sh_q);
	assign exp_d = DOUBLE_EXP_BASE - 11'(sh_q);
	assign norm_res = (req_q == REQ_FLOAT) ?
		{32'b0, 1'b0, exp_f, norm_q[FRAC_W-2:FLOAT_PAD]} :
		{1'b0, exp_d, norm_q[FRAC_W-2:0]};

	// sequencer, seed and configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			out_valid_q  <= 1'b0;
			step_start_q <= 1'b0;
			div_start_q  <= 1'b0;
			seed_q       <= '0;
			mult_q       <= 48'd25214903917;
			inc_q        <= 48'd11;
			tries_q      <= '0;
			second_q     <= 1'b0;
		end else begin
			step_start_q <= 1'b0;
			div_start_q  <= 1'b0;
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					CFG_MULTIPLIER: mult_q <= cfg_data;
					CFG_INCREMENT:  inc_q  <= cfg_data;
					default:        mult_q <= mult_q;
				endcase
			end
			if (out_load)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						tries_q  <= '0;
						second_q <= 1'b0;
						if (in_req == REQ_SET_SEED) begin
							seed_q  <= SEED_WIDTH'(s_tdata[63:0] ^ {16'b0, mult_q});
							state_q <= S_DONE;
						end else if (in_req == REQ_BOUNDED && in_bad_bound) begin
							state_q <= S_DONE;
						end else begin
							step_start_q <= 1'b1;
							state_q      <= S_STEP;
						end
					end
				end
				S_STEP: begin
					if (step_done) begin
						seed_q  <= step_next;
						state_q <= S_USE;
					end
				end
				S_USE: begin
					if (use_more) begin
						second_q     <= 1'b1;
						step_start_q <= 1'b1;
						state_q      <= S_STEP;
					end else if (use_div) begin
						div_start_q <= 1'b1;
						state_q     <= S_DIV;
					end else if (use_norm) begin
						state_q <= S_NORM;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DIV: begin
					if (div_done) begin
						if (retry) begin
							tries_q      <= tries_q + 1'b1;
							step_start_q <= 1'b1;
							state_q      <= S_STEP;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_NORM: begin
					if (norm_q[FRAC_W-1])
						state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_load)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// request fields, draw values and output word
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_result_q <= res_q;
			out_status_q <= stat_q;
		end
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					req_q   <= in_req;
					nbits_q <= in_bits;
					bound_q <= in_bound[BOUND_W-1:0];
					pow2_q  <= (in_bound & (in_bound - 32'd1)) == 32'd0;
					res_q   <= '0;
					stat_q  <= (in_req == REQ_BOUNDED) && in_bad_bound;
				end
			end
			S_USE: begin
				if (use_more) begin
					hi_q <= d;
				end else if (use_div) begin
					draw31_q <= d[BOUND_W-1:0];
				end else if (use_norm) begin
					norm_q <= frac_v;
					sh_q   <= '0;
				end else begin
					res_q <= use_res;
				end
			end
			S_DIV: begin
				if (div_done && !retry)
					res_q <= 64'(div_rem);
			end
			S_NORM: begin
				if (norm_q[FRAC_W-1]) begin
					res_q <= norm_res;
				end else begin
					norm_q <= norm_q << 1;
					sh_q   <= sh_q + 1'b1;
				end
			end
			default: res_q <= res_q;
		endcase
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'b0, out_status_q, out_result_q};

endmodule

`default_nettype wire

/* rtl/core/lcg48_step.sv */
// lcg48_step: multi-cycle congruential step, seed * multiplier + increment
// modulo 2^SEED_WIDTH, one 16-bit multiplier digit per cycle; uses lcg48_pkg
`default_nettype none

module lcg48_step import lcg48_pkg::*; #(
	parameter int SEED_WIDTH = 48
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [SEED_WIDTH-1:0] seed,
	input  wire logic [CFG_W-1:0]      mult,
	input  wire logic [CFG_W-1:0]      inc,
	output logic                       done,
	output logic [SEED_WIDTH-1:0]      next_seed
);

	localparam int DIGITS = CFG_W / MUL_DIGIT_W;
	localparam int CNT_W  = $clog2(DIGITS);

	logic                        busy_q;
	logic                        done_q;
	logic [CNT_W-1:0]            cnt_q;
	logic [SEED_WIDTH-1:0]       acc_q;
	logic [SEED_WIDTH-1:0]       seed_sh_q;
	logic [CFG_W-1:0]            mult_sh_q;
	logic [SEED_WIDTH+MUL_DIGIT_W-1:0] prod_full;

	// one partial product of the shifted seed and the current digit
	assign prod_full = seed_sh_q * mult_sh_q[MUL_DIGIT_W-1:0];

	// sequencing of the digit loop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIGITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// accumulator and operand shifters
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q     <= SEED_WIDTH'({16'b0, inc});
			seed_sh_q <= seed;
			mult_sh_q <= mult;
		end else if (busy_q) begin
			acc_q     <= acc_q + prod_full[SEED_WIDTH-1:0];
			seed_sh_q <= seed_sh_q << MUL_DIGIT_W;
			mult_sh_q <= mult_sh_q >> MUL_DIGIT_W;
		end
	end

	assign done      = done_q;
	assign next_seed = acc_q;

endmodule

`default_nettype wire

/* rtl/core/lcg48_div.sv */
// lcg48_div: restoring remainder unit for 31-bit operands, one quotient bit
// per cycle; uses lcg48_pkg
`default_nettype none

module lcg48_div import lcg48_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [BOUND_W-1:0] dividend,
	input  wire logic [BOUND_W-1:0] divisor,
	output logic                    done,
	output logic [BOUND_W-1:0]      remainder
);

	localparam int CNT_W = $clog2(BOUND_W);

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [BOUND_W-1:0] rem_q;
	logic [BOUND_W-1:0] dvd_q;
	logic [BOUND_W-1:0] dvs_q;
	logic [BOUND_W:0]   trial;
	logic [BOUND_W:0]   diff;
	logic               fits;

	// shift in the next dividend bit and try the subtraction
	assign trial = {rem_q, dvd_q[BOUND_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(BOUND_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// partial remainder and dividend shifter
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[BOUND_W-1:0] : trial[BOUND_W-1:0];
			dvd_q <= dvd_q << 1;
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

/* tb/lcg48_random_generator_tb.sv */
// lcg48_random_generator_tb: self-checking bench for the 48-bit congruential generator
// drives typed requests on the slave stream and checks every result word against
// an in-bench predictor; depends on lcg48_pkg and lcg48_random_generator only

module lcg48_random_generator_tb;
	import lcg48_pkg::*;

	localparam int SEED_W = 48;
	localparam int REDRAW_LIMIT = 1024;
	localparam logic [CFG_W-1:0] DEF_MULT = 48'd25214903917;
	localparam logic [CFG_W-1:0] DEF_INCR = 48'd11;
	localparam logic [CFG_W-1:0] ALL_ONES = 48'hFFFF_FFFF_FFFF;

	// one request as the bench sees it, with an optional hand-typed answer
	typedef struct {
		req_type_t   req;
		logic [63:0] seed_val;
		logic [31:0] bound;
		logic [5:0]  bits;
		bit          typed;
		logic [63:0] want_value;
		logic        want_status;
	} lcg_req_t;

	typedef struct {
		logic [63:0] value;
		logic        status;
	} rng_word_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [103:0]       s_tdata = '0;
	logic [2:0]         s_tuser = '0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [71:0]        m_tdata;
	logic               cfg_we = 1'b0;
	logic [0:0]         cfg_index = '0;
	logic [CFG_W-1:0]   cfg_data = '0;

	// predictor copy of the generator state and registers
	logic [SEED_W-1:0]  gen_seed = '0;
	logic [CFG_W-1:0]   gen_mult = DEF_MULT;
	logic [CFG_W-1:0]   gen_incr = DEF_INCR;

	rng_word_t          pending_words[$];
	rng_word_t          due_word;
	lcg_req_t           directed_rows[$];

	int                 tx_idle_pct = 12;
	int                 rx_idle_pct = 81;
	int                 sent_total = 0;
	int                 words_checked = 0;
	int                 mismatches = 0;
	int                 redraws = 0;
	int                 settings_used = 1;
	int                 kind_count[8];

	lcg48_random_generator #(.SEED_WIDTH(SEED_W)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// clock
	always #4 clk = ~clk;

	// result-side stall pattern
	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
	end

	// advance the seed, return its top nbits
	function automatic logic [31:0] next_draw(input int unsigned nbits);
		gen_seed = gen_seed * gen_mult + gen_incr;
		if (nbits == 0) return '0;
		if (nbits > 32) nbits = 32;
		return 32'(gen_seed >> (SEED_W - nbits));
	endfunction

	// exact ieee pattern of v / 2^fbits
	function automatic logic [63:0] ieee_fraction(input logic [63:0] v, input int fbits,
			input int mbits, input int bias);
		int p;
		logic [63:0] e;
		logic [63:0] m;
		if (v == 0) return '0;
		p = 63;
		while (p > 0 && !v[p]) p--;
		e = 64'(bias + p - fbits);
		m = (v << (mbits - p)) & ((64'd1 << mbits) - 64'd1);
		return (e << mbits) | m;
	endfunction

	// expected word for one accepted request, updates the predictor seed
	function automatic rng_word_t lcg_expected_word(input lcg_req_t rq);
		rng_word_t w;
		logic [31:0] hi_d;
		logic [31:0] lo_d;
		logic [31:0] rem;
		logic [63:0] acc;
		int unsigned tries;
		w.value = '0;
		w.status = 1'b0;
		rem = '0;
		case (rq.req)
		REQ_SET_SEED: begin
			gen_seed = rq.seed_val[SEED_W-1:0] ^ gen_mult;
		end
		REQ_INT: begin
			hi_d = next_draw(32);
			w.value = {{32{hi_d[31]}}, hi_d};
		end
		REQ_BOUNDED: begin
			if (rq.bound == 0 || rq.bound[31]) begin
				w.status = 1'b1;
			end else if ((rq.bound & (rq.bound - 32'd1)) == 0) begin
				acc = 64'(rq.bound) * 64'(next_draw(31));
				w.value = acc >> 31;
			end else begin
				// modulo with redraw of biased draws, capped for stuck sequences
				tries = 0;
				forever begin
					hi_d = next_draw(31);
					rem = hi_d % rq.bound;
					tries++;
					acc = 64'(hi_d) - 64'(rem) + 64'(rq.bound) - 64'd1;
					if (acc <= 64'h7FFF_FFFF || tries >= REDRAW_LIMIT) break;
					redraws++;
				end
				w.value = 64'(rem);
			end
		end
		REQ_LONG: begin
			hi_d = next_draw(32);
			lo_d = next_draw(32);
			w.value = {hi_d, 32'b0} + {{32{lo_d[31]}}, lo_d};
		end
		REQ_BOOL: begin
			w.value = 64'(next_draw(1));
		end
		REQ_FLOAT: begin
			w.value = ieee_fraction(64'(next_draw(24)), 24, 23, 127);
		end
		REQ_DOUBLE: begin
			hi_d = next_draw(26);
			lo_d = next_draw(27);
			acc = (64'(hi_d) << 27) + 64'(lo_d);
			w.value = ieee_fraction(acc, 53, 52, 1023);
		end
		default: begin
			w.value = 64'(next_draw(rq.bits > 6'd32 ? 32 : int'(rq.bits)));
		end
		endcase
		return w;
	endfunction

	// random request; cheap bounds keep stuck sequences from redrawing forever
	function automatic lcg_req_t random_request(input bit cheap_bounds);
		lcg_req_t rq;
		logic [31:0] r;
		r = $urandom;
		rq.typed = 1'b0;
		rq.want_value = '0;
		rq.want_status = 1'b0;
		case ($urandom_range(0, 15))
		0:       rq.req = REQ_SET_SEED;
		1, 2:    rq.req = REQ_INT;
		3, 4, 5: rq.req = REQ_BOUNDED;
		6:       rq.req = REQ_LONG;
		7:       rq.req = REQ_BOOL;
		8, 9:    rq.req = REQ_FLOAT;
		10, 11:  rq.req = REQ_DOUBLE;
		default: rq.req = REQ_RAW;
		endcase
		rq.seed_val = {$urandom, $urandom};
		case ($urandom_range(0, 9))
		0: begin
			case ($urandom_range(0, 2))
			0:       rq.bound = '0;
			1:       rq.bound = 32'h8000_0000;
			default: rq.bound = {1'b1, r[30:0]};
			endcase
		end
		1, 2:    rq.bound = 32'd1 << $urandom_range(0, 30);
		3, 4, 5: rq.bound = $urandom_range(1, 1000);
		default: rq.bound = (r[30:0] == 0) ? 32'd1 : {1'b0, r[30:0]};
		endcase
		if (cheap_bounds && !rq.bound[31] && rq.bound != 0)
			rq.bound = 32'd1 << $urandom_range(0, 30);
		if ($urandom_range(0, 9) < 7)
			rq.bits = 6'($urandom_range(0, 33));
		else
			rq.bits = 6'($urandom_range(0, 63));
		return rq;
	endfunction

	// present one request, wait for the handshake, queue its expected word
	task automatic send_request(input lcg_req_t rq);
		rng_word_t w;
		if (sent_total < 650) begin
			tx_idle_pct = 12;
			rx_idle_pct = 81;
		end else if (sent_total < 1300) begin
			tx_idle_pct = 81;
			rx_idle_pct = 12;
		end else begin
			tx_idle_pct = 0;
			rx_idle_pct = 0;
		end
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {2'b00, rq.bits, rq.bound, rq.seed_val};
		s_tuser <= rq.req;
		do @(posedge clk); while (!s_tready);
		w = lcg_expected_word(rq);
		if (rq.typed) begin
			w.value = rq.want_value;
			w.status = rq.want_status;
		end
		pending_words.push_back(w);
		kind_count[rq.req]++;
		sent_total++;
	endtask

	task automatic send_random(input int n, input bit cheap_bounds);
		repeat (n) send_request(random_request(cheap_bounds));
	endtask

	// let every outstanding word drain so registers change only when idle
	task automatic drain_words();
		s_tvalid <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// new multiplier and increment, back to back
	task automatic retune(input logic [CFG_W-1:0] mult, input logic [CFG_W-1:0] incr);
		drain_words();
		cfg_we <= 1'b1;
		cfg_index <= CFG_MULTIPLIER;
		cfg_data <= mult;
		@(posedge clk);
		cfg_index <= CFG_INCREMENT;
		cfg_data <= incr;
		@(posedge clk);
		cfg_we <= 1'b0;
		gen_mult = mult;
		gen_incr = incr;
		settings_used++;
	endtask

	task automatic add_row(input req_type_t req, input logic [63:0] seed_val,
			input logic [31:0] bound, input logic [5:0] bits, input bit typed,
			input logic [63:0] want_value, input logic want_status);
		lcg_req_t rq;
		rq.req = req;
		rq.seed_val = seed_val;
		rq.bound = bound;
		rq.bits = bits;
		rq.typed = typed;
		rq.want_value = want_value;
		rq.want_status = want_status;
		directed_rows.push_back(rq);
	endtask

	// result checker
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (pending_words.size() == 0) begin
				$display("%0t: unexpected word, expected none, got %h", $time, m_tdata);
				mismatches++;
			end else begin
				due_word = pending_words.pop_front();
				words_checked++;
				if (m_tdata[63:0] !== due_word.value) begin
					$display("%0t: result_value expected %h got %h", $time, due_word.value,
						m_tdata[63:0]);
					mismatches++;
				end
				if (m_tdata[64] !== due_word.status) begin
					$display("%0t: status expected %b got %b", $time, due_word.status,
						m_tdata[64]);
					mismatches++;
				end
			end
		end
	end

	// stimulus
	initial begin
		lcg_req_t stuck;
		logic [CFG_W-1:0] rnd_mult;
		foreach (kind_count[i]) kind_count[i] = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// seed is zero after reset, so the first int draw is the top of 11
		add_row(REQ_INT,      64'd0, 32'd0, 6'd0, 1'b1, 64'd0, 1'b0);
		add_row(REQ_BOOL,     64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 6'h3F, 1'b0, 64'd0, 1'b0);
		add_row(REQ_SET_SEED, 64'd0, 32'd0, 6'd0, 1'b1, 64'd0, 1'b0);
		add_row(REQ_INT,      64'd0, 32'd0, 6'd0, 1'b0, 64'd0, 1'b0);
		add_row(REQ_LONG,     64'd0, 32'd0, 6'd0, 1'b0, 64'd0, 1'b0);
		add_row(REQ_FLOAT,    64'd0, 32'd0, 6'd0, 1'b0, 64'd0, 1'b0);
		add_row(REQ_DOUBLE,   64'd0, 32'd0, 6'd0, 1'b0, 64'd0, 1'b0);
		// zero bit count still steps the seed
		add_row(REQ_RAW,      64'd0, 32'd0, 6'd0, 1'b1, 64'd0, 1'b0);
		add_row(REQ_RAW,      64'd0, 32'd0, 6'd1, 1'b0, 64'd0, 1'b0);
		add_row(REQ_RAW,      64'd0, 32'd0, 6'd32, 1'b0, 64'd0, 1'b0);
		add_row(REQ_RAW,      64'd0, 32'd0, 6'd33, 1'b0, 64'd0, 1'b0);
		add_row(REQ_RAW,      64'd0, 32'd0, 6'd63, 1'b0, 64'd0, 1'b0);
		// non-positive bounds flag an error, positive ones do not
		add_row(REQ_BOUNDED,  64'd0, 32'd0, 6'd0, 1'b1, 64'd0, 1'b1);
		add_row(REQ_BOUNDED,  64'd0, 32'hFFFF_FFFF, 6'd0, 1'b1, 64'd0, 1'b1);
		add_row(REQ_BOUNDED,  64'd0, 32'h8000_0000, 6'd0, 1'b1, 64'd0, 1'b1);
		add_row(REQ_BOUNDED,  64'd0, 32'd1, 6'd0, 1'b1, 64'd0, 1'b0);
		add_row(REQ_BOUNDED,  64'd0, 32'h4000_0000, 6'd0, 1'b0, 64'd0, 1'b0);
		add_row(REQ_BOUNDED,  64'd0, 32'h7FFF_FFFF, 6'd0, 1'b0, 64'd0, 1'b0);
		add_row(REQ_BOUNDED,  64'd0, 32'd3, 6'd0, 1'b0, 64'd0, 1'b0);
		// close to half of the draws get redrawn here
		add_row(REQ_BOUNDED,  64'd0, 32'h4000_0001, 6'd0, 1'b0, 64'd0, 1'b0);
		add_row(REQ_SET_SEED, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 6'd0, 1'b1, 64'd0, 1'b0);
		add_row(REQ_SET_SEED, 64'h8000_0000_0000_0000, 32'd0, 6'd0, 1'b1, 64'd0, 1'b0);
		// seed equal to the multiplier clears the state: the float is exactly zero
		add_row(REQ_SET_SEED, 64'(DEF_MULT), 32'd0, 6'd0, 1'b1, 64'd0, 1'b0);
		add_row(REQ_FLOAT,    64'd0, 32'd0, 6'd0, 1'b1, 64'd0, 1'b0);
		add_row(REQ_DOUBLE,   64'd0, 32'd0, 6'd0, 1'b0, 64'd0, 1'b0);
		foreach (directed_rows[i]) send_request(directed_rows[i]);

		send_random(500, 1'b0);

		// zero multiplier pins the seed at all ones: every modulo draw is rejected
		retune('0, ALL_ONES);
		stuck = directed_rows[0];
		stuck.req = REQ_BOUNDED;
		stuck.bound = 32'h4000_0001;
		stuck.typed = 1'b0;
		send_request(stuck);
		send_random(40, 1'b1);

		// largest multiplier, no increment: the seed only flips sign
		retune(ALL_ONES, '0);
		send_random(40, 1'b1);

		repeat (3) begin
			rnd_mult = 48'({$urandom, $urandom}) | 48'd1;
			retune(rnd_mult, 48'({$urandom, $urandom}));
			send_random(250, 1'b0);
		end

		retune(DEF_MULT, '0);
		send_random(200, 1'b0);

		retune(DEF_MULT, DEF_INCR);
		send_random(450, 1'b0);

		drain_words();
		repeat (60) @(posedge clk);
		$display("covered %0d requests (%0d set seed, %0d bounded, %0d redraws) over %0d settings",
			sent_total, kind_count[REQ_SET_SEED], kind_count[REQ_BOUNDED], redraws,
			settings_used);
		$display("checked %0d result words with sender and receiver stalls swapped", words_checked);
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// watchdog
	initial begin
		#32_000_000;
		$display("%0t: watchdog expired, %0d words outstanding", $time, pending_words.size());
		$display("simulation failed");
		$finish;
	end

endmodule

/* lcg48_random_generator.f */
rtl/core/lcg48_pkg.sv
rtl/core/lcg48_step.sv
rtl/core/lcg48_div.sv
rtl/core/lcg48_random_generator.sv
tb/lcg48_random_generator_tb.sv
